[hw/rtl/vertex_light_color_blend_unit_assert.svh]
// Assertion macros for the vertex light color blend unit
`ifndef VERTEX_LIGHT_COLOR_BLEND_UNIT_ASSERT_SVH
`define VERTEX_LIGHT_COLOR_BLEND_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define VLCB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vlcb: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define VLCB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vlcb: next-cycle check failed");

`endif

[hw/rtl/vlcb_pkg.sv]
// Package: types, widths and codes of the vertex light color blend unit
package vlcb_pkg;

  localparam int FRAC_BITS = 12;
  localparam int CRD_W     = 24;
  localparam int OPD_W     = CRD_W + 1;
  localparam int PRD_W     = 2 * OPD_W;
  localparam int SUM_W     = PRD_W + 2;
  localparam int RAD_W     = 23;
  localparam int SQ_W      = 2 * RAD_W;
  localparam int ROOT_W    = RAD_W;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int LF_W      = FRAC_BITS + 2;
  localparam int C_W       = FRAC_BITS + 1;
  localparam int COL_W     = 8;
  localparam int RGB_W     = 3 * COL_W;
  localparam int BL_W      = C_W + COL_W + 1;
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int OB_DEPTH  = 2;
  localparam int OB_PTR_W  = $clog2(OB_DEPTH);

  localparam logic signed [LF_W-1:0] LF_ONE = LF_W'(1) << FRAC_BITS;
  localparam logic [C_W-1:0]         C_ONE  = C_W'(1) << FRAC_BITS;

  localparam logic [MODE_W-1:0] MODE_DIR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AMB = 2'd2;

  localparam logic signed [CRD_W-1:0] VZ_RST  = CRD_W'(1) << FRAC_BITS;
  localparam logic [RAD_W-1:0]        RAD_RST = RAD_W'(10) << FRAC_BITS;
  localparam logic [RGB_W-1:0]        SPEC_RST = 24'hFFFFFF;
  localparam logic [RGB_W-1:0]        DIFF_RST = 24'hC80000;
  localparam logic [RGB_W-1:0]        AMB_RST  = 24'h460000;

  typedef enum logic [1:0] {LC_DIR, LC_PT, LC_AMB} lcls_t;

  typedef enum logic [2:0] {
    REG_MODE, REG_VX, REG_VY, REG_VZ, REG_RAD, REG_SPEC, REG_DIFF, REG_AMB
  } reg_idx_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] normal_x;
    logic signed [CRD_W-1:0] normal_y;
    logic signed [CRD_W-1:0] normal_z;
    logic signed [CRD_W-1:0] pos_x;
    logic signed [CRD_W-1:0] pos_y;
    logic signed [CRD_W-1:0] pos_z;
    logic                    last_in;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
    logic             last_out;
  } out_t;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic signed [CRD_W-1:0] vx;
    logic signed [CRD_W-1:0] vy;
    logic signed [CRD_W-1:0] vz;
    logic [RAD_W-1:0]        rad;
    logic [SQ_W-1:0]         r2;
    logic [RGB_W-1:0]        spec;
    logic [RGB_W-1:0]        diff;
    logic [RGB_W-1:0]        amb;
  } cfg_t;

  typedef struct packed {
    lcls_t                   cls;
    logic                    last;
    logic signed [OPD_W-1:0] a0;
    logic signed [OPD_W-1:0] a1;
    logic signed [OPD_W-1:0] a2;
    logic signed [OPD_W-1:0] b0;
    logic signed [OPD_W-1:0] b1;
    logic signed [OPD_W-1:0] b2;
  } op_t;

endpackage

[hw/rtl/vlcb_cfg.sv]
// Configuration registers with APB-style access
module vlcb_cfg import vlcb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [MODE_W-1:0]       mode_r;
  logic signed [CRD_W-1:0] vx_r, vy_r, vz_r;
  logic [RAD_W-1:0]        rad_r;
  logic [SQ_W-1:0]         r2_r;
  logic [RGB_W-1:0]        spec_r, diff_r, amb_r;
  logic                    wr;
  reg_idx_t                idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DIR;
      vx_r   <= '0;
      vy_r   <= '0;
      vz_r   <= VZ_RST;
      rad_r  <= RAD_RST;
      spec_r <= SPEC_RST;
      diff_r <= DIFF_RST;
      amb_r  <= AMB_RST;
    end else if (wr) begin
      unique case (idx)
        REG_MODE: mode_r <= pwdata[MODE_W-1:0];
        REG_VX:   vx_r   <= pwdata[CRD_W-1:0];
        REG_VY:   vy_r   <= pwdata[CRD_W-1:0];
        REG_VZ:   vz_r   <= pwdata[CRD_W-1:0];
        REG_RAD:  rad_r  <= pwdata[RAD_W-1:0];
        REG_SPEC: spec_r <= pwdata[RGB_W-1:0];
        REG_DIFF: diff_r <= pwdata[RGB_W-1:0];
        REG_AMB:  amb_r  <= pwdata[RGB_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2_r <= SQ_W'(rad_r) * SQ_W'(rad_r);
  end

  always_comb begin
    unique case (idx)
      REG_MODE: prdata = DATA_W'(mode_r);
      REG_VX:   prdata = DATA_W'(vx_r);
      REG_VY:   prdata = DATA_W'(vy_r);
      REG_VZ:   prdata = DATA_W'(vz_r);
      REG_RAD:  prdata = DATA_W'(rad_r);
      REG_SPEC: prdata = DATA_W'(spec_r);
      REG_DIFF: prdata = DATA_W'(diff_r);
      REG_AMB:  prdata = DATA_W'(amb_r);
    endcase
  end

  assign cfg = '{mode: mode_r, vx: vx_r, vy: vy_r, vz: vz_r, rad: rad_r, r2: r2_r,
                 spec: spec_r, diff: diff_r, amb: amb_r};

endmodule

[hw/rtl/vlcb_front.sv]
// Front end: classify a vertex by light mode and form multiplier operands
module vlcb_front import vlcb_pkg::*; (
  input  in_t  in_data,
  input  cfg_t cfg,
  output op_t  op
);

  logic signed [OPD_W-1:0] dx, dy, dz;

  assign dx = OPD_W'(in_data.pos_x) - OPD_W'(cfg.vx);
  assign dy = OPD_W'(in_data.pos_y) - OPD_W'(cfg.vy);
  assign dz = OPD_W'(in_data.pos_z) - OPD_W'(cfg.vz);

  always_comb begin
    op.last = in_data.last_in;
    unique case (cfg.mode)
      MODE_DIR: begin
        op.cls = LC_DIR;
        op.a0  = OPD_W'(in_data.normal_x);
        op.a1  = OPD_W'(in_data.normal_y);
        op.a2  = OPD_W'(in_data.normal_z);
        op.b0  = OPD_W'(cfg.vx);
        op.b1  = OPD_W'(cfg.vy);
        op.b2  = OPD_W'(cfg.vz);
      end
      MODE_PT: begin
        op.cls = LC_PT;
        op.a0  = dx;
        op.a1  = dy;
        op.a2  = dz;
        op.b0  = dx;
        op.b1  = dy;
        op.b2  = dz;
      end
      default: begin
        op.cls = LC_AMB;
        op.a0  = '0;
        op.a1  = '0;
        op.a2  = '0;
        op.b0  = '0;
        op.b1  = '0;
        op.b2  = '0;
      end
    endcase
  end

endmodule

[hw/rtl/vlcb_queue.sv]
// Short queue between front end and back end
module vlcb_queue import vlcb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  op_t  wr_data,
  input  logic rd_en,
  output op_t  rd_data,
  output logic q_full,
  output logic q_empty
);

  op_t               mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign q_full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 1'b1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[hw/rtl/vlcb_back.sv]
// Back end: dot product or distance, square root, divide, color blend, result buffer
module vlcb_back import vlcb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  op_t  q_head,
  input  logic q_empty,
  output logic q_pop,
  input  logic pop,
  output logic empty,
  output out_t out_data
);

  localparam int NSTG = 2 + (ROOT_W + 1) + (QUO_W + 1) + 1;
  localparam int RT0  = 2;
  localparam int DV0  = RT0 + ROOT_W + 1;
  localparam logic signed [SUM_W-1:0] ONE2 = SUM_W'(1) << (2 * FRAC_BITS);

  typedef struct packed {
    lcls_t                  cls;
    logic                   last;
    logic                   far;
    logic signed [LF_W-1:0] lf;
    logic [SQ_W-1:0]        v;
    logic [SQ_W-1:0]        res;
  } rt_t;

  typedef struct packed {
    lcls_t                  cls;
    logic                   last;
    logic                   far;
    logic signed [LF_W-1:0] lf;
    logic [RAD_W:0]         rem;
    logic [QUO_W-1:0]       q;
  } dv_t;

  function automatic rt_t rt_step(rt_t x, int k);
    logic [SQ_W-1:0] bitv;
    logic [SQ_W-1:0] rb;
    rt_t             y;
    bitv = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    rb   = x.res + bitv;
    y    = x;
    if (x.v >= rb) begin
      y.v   = x.v - rb;
      y.res = (x.res >> 1) + bitv;
    end else begin
      y.res = x.res >> 1;
    end
    return y;
  endfunction

  function automatic dv_t dv_step(dv_t x, logic [RAD_W-1:0] r);
    logic [RAD_W:0] t;
    dv_t            y;
    t = {x.rem[RAD_W-1:0], 1'b0};
    y = x;
    if (t >= {1'b0, r}) begin
      y.rem = t - {1'b0, r};
      y.q   = {x.q[QUO_W-2:0], 1'b1};
    end else begin
      y.rem = t;
      y.q   = {x.q[QUO_W-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic logic [COL_W-1:0] blend(logic [C_W-1:0] c1, logic [COL_W-1:0] a,
                                             logic [COL_W-1:0] d);
    logic [BL_W-1:0] s;
    s = BL_W'(c1) * BL_W'(a) + BL_W'(C_ONE - c1) * BL_W'(d);
    return s[FRAC_BITS+COL_W-1:FRAC_BITS];
  endfunction

  logic [NSTG-1:0]         vld_r;
  logic                    adv;
  lcls_t                   cls1_r, cls2_r;
  logic                    last1_r, last2_r;
  logic signed [PRD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [SUM_W-1:0] sum2_r;
  logic signed [SUM_W-1:0] neg, sat;
  rt_t                     rt_in;
  rt_t                     rt_r [ROOT_W+1];
  dv_t                     dv_r [QUO_W+1];
  dv_t                     dv_in;
  dv_t                     dv_end;
  logic signed [LF_W-1:0]  lf;
  logic [C_W-1:0]          c1_r;
  logic [RGB_W-1:0]        cola_r;
  logic                    lastc_r;
  out_t                    res_out;
  out_t                    ob_r [OB_DEPTH];
  logic [OB_PTR_W-1:0]     ob_wp_r, ob_rp_r;
  logic [OB_PTR_W:0]       ob_cnt_r;
  logic                    ob_wr, ob_rd;

  assign adv   = !vld_r[NSTG-1] || (ob_cnt_r != (OB_PTR_W+1)'(OB_DEPTH));
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cls1_r  <= q_head.cls;
      last1_r <= q_head.last;
      p0_r    <= PRD_W'(q_head.a0) * PRD_W'(q_head.b0);
      p1_r    <= PRD_W'(q_head.a1) * PRD_W'(q_head.b1);
      p2_r    <= PRD_W'(q_head.a2) * PRD_W'(q_head.b2);
      cls2_r  <= cls1_r;
      last2_r <= last1_r;
      sum2_r  <= SUM_W'(p0_r) + SUM_W'(p1_r) + SUM_W'(p2_r);
    end
  end

  always_comb begin
    neg = -sum2_r;
    priority if (neg > ONE2) sat = ONE2;
    else if (neg < -ONE2)    sat = -ONE2;
    else                     sat = neg;
    rt_in.cls  = cls2_r;
    rt_in.last = last2_r;
    rt_in.far  = (sum2_r >= $signed(SUM_W'(cfg.r2)));
    rt_in.lf   = LF_W'(sat >>> FRAC_BITS);
    rt_in.v    = sum2_r[SQ_W-1:0];
    rt_in.res  = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) rt_r[0] <= rt_in;
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (adv) rt_r[k+1] <= rt_step(rt_r[k], k);
    end
  end

  always_comb begin
    dv_in.cls  = rt_r[ROOT_W].cls;
    dv_in.last = rt_r[ROOT_W].last;
    dv_in.far  = rt_r[ROOT_W].far;
    dv_in.lf   = rt_r[ROOT_W].lf;
    dv_in.rem  = {1'b0, rt_r[ROOT_W].res[RAD_W-1:0]};
    dv_in.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) dv_r[0] <= dv_in;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) dv_r[k+1] <= dv_step(dv_r[k], cfg.rad);
    end
  end

  assign dv_end = dv_r[QUO_W];

  always_comb begin
    unique case (dv_end.cls)
      LC_DIR:  lf = dv_end.lf;
      LC_PT:   lf = dv_end.far ? -LF_ONE : LF_ONE - $signed(LF_W'(dv_end.q));
      default: lf = -LF_ONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r    <= C_W'((lf < 0) ? -lf : lf);
      cola_r  <= (lf > 0) ? cfg.spec : cfg.amb;
      lastc_r <= dv_end.last;
    end
  end

  always_comb begin
    res_out.red      = blend(c1_r, cola_r[3*COL_W-1:2*COL_W], cfg.diff[3*COL_W-1:2*COL_W]);
    res_out.green    = blend(c1_r, cola_r[2*COL_W-1:COL_W], cfg.diff[2*COL_W-1:COL_W]);
    res_out.blue     = blend(c1_r, cola_r[COL_W-1:0], cfg.diff[COL_W-1:0]);
    res_out.last_out = lastc_r;
  end

  assign ob_wr    = adv && vld_r[NSTG-1];
  assign ob_rd    = pop && !empty;
  assign empty    = (ob_cnt_r == '0);
  assign out_data = ob_r[ob_rp_r];

  always_ff @(posedge clk) begin
    if (ob_wr) ob_r[ob_wp_r] <= res_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r  <= '0;
      ob_rp_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (ob_wr) ob_wp_r <= ob_wp_r + 1'b1;
      if (ob_rd) ob_rp_r <= ob_rp_r + 1'b1;
      if (ob_wr && !ob_rd) ob_cnt_r <= ob_cnt_r + 1'b1;
      else if (ob_rd && !ob_wr) ob_cnt_r <= ob_cnt_r - 1'b1;
    end
  end

endmodule

[hw/rtl/vertex_light_color_blend_unit.sv]
// Top level of the vertex light color blend unit
//
//   port group   direction   transfer when
//   in_data      in          push && !full
//   out_data     out         pop && !empty
//   cfg (APB)    in/out      psel && penable && pwrite
//
// One vertex per cycle sustained while the back end is not held; each result passes
// through the 23-step square root and 13-step divide pipeline on its way to out_data.
// Reset is synchronous, active low; it empties both queues and restores registers.
// When the two-entry result buffer is full and a result waits at the pipeline end, the
// back end holds; the four-entry middle queue then fills and full rises.
`include "vertex_light_color_blend_unit_assert.svh"
module vertex_light_color_blend_unit import vlcb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  in_t               in_data,
  output logic              empty,
  input  logic              pop,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  op_t  fe_op;
  op_t  q_head;
  logic q_full, q_empty, q_pop;

  vlcb_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  vlcb_front u_front (
    .in_data, .cfg, .op(fe_op)
  );

  vlcb_queue u_queue (
    .clk, .rst_n,
    .wr_en(push && !q_full), .wr_data(fe_op),
    .rd_en(q_pop), .rd_data(q_head),
    .q_full, .q_empty
  );

  vlcb_back u_back (
    .clk, .rst_n, .cfg, .q_head, .q_empty, .q_pop, .pop, .empty, .out_data
  );

  assign full = q_full;

  `VLCB_ASSERT_IMPL(a_q_excl, q_full, !q_empty)
  `VLCB_ASSERT_IMPL(a_empty_rise, $rose(empty), $past(pop))
  `VLCB_ASSERT_IMPL(a_full_rise, $rose(full), $past(push))
  `VLCB_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty)

endmodule

[tb/tb_vertex_light_color_blend_unit.sv]
// Self-checking testbench of the vertex light color blend unit
`timescale 1ns / 100ps
module tb_vertex_light_color_blend_unit;
  import vlcb_pkg::*;

  localparam int LATENCY = 42;
  localparam int N_RANDOM = 1950;
  localparam int CYCLE_LIMIT = 400000;

  logic clk, rst_n, push, full, empty, pop;
  in_t in_data;
  out_t out_data;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  vertex_light_color_blend_unit u_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .psel(psel),
    .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  typedef struct {
    in_t  vtx;
    bit   known;
    out_t color;
  } vtx_row_t;

  logic [1:0] mode_q;
  longint vx_q, vy_q, vz_q;
  longint rad_q;
  logic [23:0] spec_q, diff_q, amb_q;

  out_t color_q[$];
  int errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] d, longint c1, longint c2);
    longint s;
    s = c1 * longint'(a) + c2 * longint'(d);
    return 8'(s >>> FRAC_BITS);
  endfunction

  function automatic out_t light_vertex(in_t v);
    longint one, one2, lf, dot, c1, c2, dx, dy, dz;
    longint unsigned sq, d, q;
    logic [23:0] col;
    out_t r;
    one = 64'sd1 << FRAC_BITS;
    one2 = one << FRAC_BITS;
    if (mode_q == MODE_DIR) begin
      dot = -(longint'(v.normal_x) * vx_q + longint'(v.normal_y) * vy_q
              + longint'(v.normal_z) * vz_q);
      if (dot > one2) dot = one2;
      if (dot < -one2) dot = -one2;
      lf = dot >>> FRAC_BITS;
    end else if (mode_q == MODE_PT) begin
      dx = longint'(v.pos_x) - vx_q;
      dy = longint'(v.pos_y) - vy_q;
      dz = longint'(v.pos_z) - vz_q;
      sq = dx * dx + dy * dy + dz * dz;
      if (sq >= longint'(rad_q * rad_q)) begin
        lf = -one;
      end else begin
        d = int_sqrt(sq);
        q = (2 * d * one) / rad_q;
        lf = one - longint'(q);
      end
    end else begin
      lf = -one;
    end
    c1 = lf < 0 ? -lf : lf;
    c2 = one - c1;
    col = lf > 0 ? spec_q : amb_q;
    r.red = blend(col[23:16], diff_q[23:16], c1, c2);
    r.green = blend(col[15:8], diff_q[15:8], c1, c2);
    r.blue = blend(col[7:0], diff_q[7:0], c1, c2);
    r.last_out = v.last_in;
    return r;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = ADDR_W'(4 * int'(idx)); pwdata = val;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      REG_MODE: mode_q = val[1:0];
      REG_VX:   vx_q = longint'($signed(val[23:0]));
      REG_VY:   vy_q = longint'($signed(val[23:0]));
      REG_VZ:   vz_q = longint'($signed(val[23:0]));
      REG_RAD:  rad_q = longint'(val[22:0]);
      REG_SPEC: spec_q = val[23:0];
      REG_DIFF: diff_q = val[23:0];
      default:  amb_q = val[23:0];
    endcase
  endtask

  task automatic send_vertex(in_t v, bit known, out_t color);
    int gap;
    gap = $urandom_range(0, 13);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(negedge clk);
    push = 1;
    in_data = v;
    @(posedge clk);
    while (full) @(posedge clk);
    color_q.push_back(known ? color : light_vertex(v));
    @(negedge clk);
    push = 0;
  endtask

  task automatic drain;
    while (color_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic in_t rand_vertex(bit unit_normals);
    in_t v;
    v = in_t'($bits(in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if (unit_normals) begin
      v.normal_x = 24'($signed($urandom_range(0, 8192)) - 4096);
      v.normal_y = 24'($signed($urandom_range(0, 8192)) - 4096);
      v.normal_z = 24'($signed($urandom_range(0, 8192)) - 4096);
      v.pos_x = 24'($signed($urandom_range(0, 98304)) - 49152);
      v.pos_y = 24'($signed($urandom_range(0, 98304)) - 49152);
      v.pos_z = 24'($signed($urandom_range(0, 98304)) - 49152);
    end
    return v;
  endfunction

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (color_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none actual %h", $time, out_data);
        errors++;
      end else begin
        if (out_data.red !== color_q[0].red)
          $display("%0t: red expected %h actual %h", $time, color_q[0].red, out_data.red);
        if (out_data.green !== color_q[0].green)
          $display("%0t: green expected %h actual %h", $time,
                   color_q[0].green, out_data.green);
        if (out_data.blue !== color_q[0].blue)
          $display("%0t: blue expected %h actual %h", $time, color_q[0].blue, out_data.blue);
        if (out_data.last_out !== color_q[0].last_out)
          $display("%0t: last_out expected %b actual %b", $time,
                   color_q[0].last_out, out_data.last_out);
        if (out_data !== color_q[0]) errors++;
        void'(color_q.pop_front());
      end
    end
  end

  initial begin
    int stall;
    forever begin
      @(negedge clk);
      if (pop && !empty) stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      else stall = 0;
      if (stall != 0) begin
        pop = 0;
        repeat (stall - 1) @(negedge clk);
      end
      pop = 1;
    end
  end

  initial begin
    vtx_row_t rows[$];
    in_t v;
    out_t none;
    logic [31:0] cfg_val[8];
    rst_n = 0; push = 0; pop = 0; in_data = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    mode_q = MODE_DIR; vx_q = 0; vy_q = 0; vz_q = 4096; rad_q = 40960;
    spec_q = SPEC_RST; diff_q = DIFF_RST; amb_q = AMB_RST;
    none = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // reset light points +z; normal -z gives full specular, +z full ambient
    v = '0; v.normal_z = -24'sd4096;
    rows.push_back('{v, 1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}});
    v = '0; v.normal_z = 24'sd4096; v.last_in = 1;
    rows.push_back('{v, 1, '{8'h46, 8'h00, 8'h00, 1'b1}});
    v = '0;
    rows.push_back('{v, 1, '{8'hC8, 8'h00, 8'h00, 1'b0}});
    v = '0; v.normal_z = 24'sh800000;
    rows.push_back('{v, 1, '{8'hFF, 8'hFF, 8'hFF, 1'b0}});
    v = '0; v.normal_z = 24'sh7FFFFF;
    rows.push_back('{v, 1, '{8'h46, 8'h00, 8'h00, 1'b0}});
    v = '1;
    rows.push_back('{v, 0, none});
    v = '0; v.normal_x = 24'sh7FFFFF; v.normal_y = 24'sh800000; v.pos_x = 24'sh800000;
    rows.push_back('{v, 0, none});
    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].known, rows[i].color);
    drain();

    // point light with zero, largest and unit radius, unused mode, ambient mode, then directional with extremes
    reg_write(REG_MODE, 32'(MODE_PT));
    reg_write(REG_RAD, 32'd0);
    v = '0; send_vertex(v, 1, '{8'h46, 8'h00, 8'h00, 1'b0});
    drain();
    reg_write(REG_RAD, 32'h7FFFFF);
    v = '0; v.pos_z = 24'sd4096; send_vertex(v, 0, none);
    v = '1; send_vertex(v, 0, none);
    v = '0; v.pos_x = 24'sh800000; v.pos_y = 24'sh800000; v.pos_z = 24'sh800000;
    send_vertex(v, 0, none);
    drain();
    reg_write(REG_RAD, 32'd1);
    v = '0; v.pos_z = 24'sd4096; send_vertex(v, 0, none);
    drain();
    reg_write(REG_MODE, 32'd3);
    v = rand_vertex(0); send_vertex(v, 1, '{8'h46, 8'h00, 8'h00, v.last_in});
    drain();
    reg_write(REG_MODE, 32'(MODE_AMB));
    v = rand_vertex(0); send_vertex(v, 1, '{8'h46, 8'h00, 8'h00, v.last_in});
    drain();
    reg_write(REG_MODE, 32'(MODE_DIR));
    reg_write(REG_VX, 32'h800000);
    reg_write(REG_VY, 32'h7FFFFF);
    reg_write(REG_VZ, 32'h000000);
    reg_write(REG_SPEC, 32'h000000);
    reg_write(REG_DIFF, 32'hFFFFFF);
    reg_write(REG_AMB, 32'hFFFFFF);
    for (int i = 0; i < 6; i++) send_vertex(rand_vertex(i[0]), 0, none);
    drain();

    for (int phase = 0; phase < 15; phase++) begin
      cfg_val[0] = $urandom_range(0, 3);
      if (cfg_val[0] == 3 && $urandom_range(0, 1)) cfg_val[0] = 0;
      for (int k = 1; k < 4; k++)
        cfg_val[k] = $urandom_range(0, 1) ? 32'($signed($urandom_range(0, 8192)) - 4096)
                                            : $urandom;
      cfg_val[4] = $urandom_range(0, 1) ? $urandom_range(1, 200000) : $urandom;
      if (phase == 3) cfg_val[4] = 32'h7FFFFF;
      if (phase == 4) cfg_val[4] = 1;
      for (int k = 5; k < 8; k++) cfg_val[k] = $urandom;
      for (int k = 0; k < 8; k++) reg_write(reg_idx_t'(k), cfg_val[k]);
      for (int i = 0; i < N_RANDOM / 15; i++)
        send_vertex(rand_vertex($urandom_range(0, 3) != 0), 0, none);
      drain();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/vlcb_pkg.sv
hw/rtl/vlcb_cfg.sv
hw/rtl/vlcb_front.sv
hw/rtl/vlcb_queue.sv
hw/rtl/vlcb_back.sv
hw/rtl/vertex_light_color_blend_unit.sv
tb/tb_vertex_light_color_blend_unit.sv
